### sv/moesi_pkg.sv
package moesi_pkg;

    // Fixed geometry of the line and the address fields.
    localparam int OFF_W     = 5;
    localparam int TAG_W     = 20;
    localparam int TAG_LSB   = 12;
    localparam int LA_W      = 32 - OFF_W;
    localparam int MAX_SET_W = 12;
    localparam int NWAYS     = 8;
    localparam int WAY_W     = 3;
    localparam int ST_W      = 3;
    localparam int PLRU_W    = 7;

    // Default parameter values.
    localparam int DEF_SETS = 128;

    // Command codes.
    localparam logic [2:0] CMD_CPU_RD  = 3'd0;
    localparam logic [2:0] CMD_CPU_WR  = 3'd1;
    localparam logic [2:0] CMD_SN_RD   = 3'd2;
    localparam logic [2:0] CMD_SN_RDX  = 3'd3;
    localparam logic [2:0] CMD_SN_WR   = 3'd4;

    // Line state codes.
    localparam logic [2:0] ST_I = 3'd0;
    localparam logic [2:0] ST_S = 3'd1;
    localparam logic [2:0] ST_O = 3'd2;
    localparam logic [2:0] ST_E = 3'd3;
    localparam logic [2:0] ST_M = 3'd4;

    // Bus request codes.
    localparam logic [1:0] BUS_NONE = 2'd0;
    localparam logic [1:0] BUS_RD   = 2'd1;
    localparam logic [1:0] BUS_RDX  = 2'd2;
    localparam logic [1:0] BUS_WR   = 2'd3;

    // Tree pseudo-LRU tables.
    localparam logic [6:0] PICK_MASK [7] = '{7'h0B, 7'h0B, 7'h13, 7'h13, 7'h25, 7'h25, 7'h45};
    localparam logic [6:0] PICK_VAL  [7] = '{7'h00, 7'h08, 7'h02, 7'h12, 7'h01, 7'h21, 7'h05};
    localparam logic [6:0] TOUCH_OR  [8] = '{7'h0B, 7'h03, 7'h11, 7'h01,
                                             7'h24, 7'h04, 7'h40, 7'h00};
    localparam logic [6:0] TOUCH_AND [8] = '{7'h7F, 7'h77, 7'h7D, 7'h6D,
                                             7'h7E, 7'h5E, 7'h7A, 7'h3A};

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] address;
        logic [3:0]  requester_id;
        logic        peer_supplied;
    } t_in;

    typedef struct packed {
        logic       hit;
        logic [1:0] bus_request;
        logic [2:0] way_used;
        logic [2:0] new_state;
        logic       victim_owned;
        logic       supply_data;
    } t_out;

    typedef enum logic [2:0] {
        K_NOP,
        K_RD,
        K_WR,
        K_SRD,
        K_SINV
    } t_kind;

    // A classified operation as handed from the front to the back.
    typedef struct packed {
        t_kind                  kind;
        logic [TAG_W-1:0]       tag;
        logic [MAX_SET_W-1:0]   set;
        logic                   peer;
    } t_op;

    // Classify one transaction.
    function automatic t_op mk_op(t_in in, logic [3:0] cid, logic [MAX_SET_W-1:0] set);
        t_op op;
        op.tag  = in.address[TAG_LSB +: TAG_W];
        op.set  = set;
        op.peer = in.peer_supplied;
        if (in.cmd == CMD_CPU_RD) begin
            op.kind = K_RD;
        end else if (in.cmd == CMD_CPU_WR) begin
            op.kind = K_WR;
        end else if (in.requester_id == cid) begin
            op.kind = K_NOP;
        end else if (in.cmd == CMD_SN_RD) begin
            op.kind = K_SRD;
        end else if (in.cmd == CMD_SN_RDX || in.cmd == CMD_SN_WR) begin
            op.kind = K_SINV;
        end else begin
            op.kind = K_NOP;
        end
        return op;
    endfunction

    // Way the tree points to.
    function automatic logic [WAY_W-1:0] plru_pick(logic [PLRU_W-1:0] t);
        logic [WAY_W-1:0] w;
        w = WAY_W'(7);
        for (int i = 6; i >= 0; i--) begin
            if ((t & PICK_MASK[i]) == PICK_VAL[i]) begin
                w = WAY_W'(i);
            end
        end
        return w;
    endfunction

    // Point the tree away from a way just used.
    function automatic logic [PLRU_W-1:0] plru_touch(logic [PLRU_W-1:0] t,
                                                     logic [WAY_W-1:0] w);
        return (t | TOUCH_OR[w]) & TOUCH_AND[w];
    endfunction

endpackage

### sv/moesi_front.sv
module moesi_front import moesi_pkg::*; #(
    parameter int SETS = DEF_SETS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in        i_in,
    input  logic [3:0] i_cache_id,
    input  logic       i_clearing,
    input  logic       i_full,
    output logic       o_push,
    output t_op        o_op
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam bit POW2  = (SETS == (1 << SET_W));

    generate
        if (POW2) begin : g_pow2
            logic [MAX_SET_W-1:0] set;

            // The set is a plain bit field of the address.
            always_comb begin
                set = '0;
                set[SET_W-1:0] = i_in.address[OFF_W +: SET_W];
            end

            assign o_ready = !i_full && !i_clearing;
            assign o_push  = i_valid && o_ready;
            assign o_op    = mk_op(i_in, i_cache_id, set);
        end else begin : g_mod
            localparam int STEP  = 4;
            localparam int NSTEP = (LA_W + STEP - 1) / STEP;
            localparam int PAD_W = NSTEP * STEP;
            localparam int CNT_W = $clog2(NSTEP + 1);

            logic             r_busy;
            logic [CNT_W-1:0] r_cnt;
            logic [PAD_W-1:0] r_la;
            logic [SET_W-1:0] r_rem;
            t_in              r_item;
            logic [SET_W-1:0] n_rem;
            logic [SET_W:0]   acc;
            logic             done;
            logic [MAX_SET_W-1:0] set;

            // Four remainder steps per cycle, most significant bits first.
            always_comb begin
                acc = '0;
                n_rem = r_rem;
                for (int b = 0; b < STEP; b++) begin
                    acc = {n_rem, r_la[PAD_W-1-b]};
                    if (acc >= (SET_W+1)'(SETS)) begin
                        acc = acc - (SET_W+1)'(SETS);
                    end
                    n_rem = acc[SET_W-1:0];
                end
            end

            assign done = r_busy && (r_cnt == CNT_W'(NSTEP));

            always_comb begin
                set = '0;
                set[SET_W-1:0] = r_rem;
            end

            assign o_ready = !r_busy && !i_clearing;
            assign o_push  = done && !i_full;
            assign o_op    = mk_op(r_item, i_cache_id, set);

            // Item capture and the remainder sequence.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_cnt  <= '0;
                end else if (i_valid && o_ready) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_item <= i_in;
                    r_rem  <= '0;
                    r_la   <= PAD_W'(i_in.address[31:OFF_W]);
                end else if (r_busy && !done) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_rem <= n_rem;
                    r_la  <= r_la << STEP;
                end else if (o_push) begin
                    r_busy <= 1'b0;
                end
            end
        end
    endgenerate

endmodule

### sv/moesi_queue.sv
module moesi_queue import moesi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_nempty,
    input  logic i_pop,
    output t_op  o_op
);

    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full   = (r_cnt == 2'd2);
    assign o_nempty = (r_cnt != 2'd0);
    assign o_op     = r_mem[r_rp];

    // Two-entry queue between the front and the back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_op;
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### sv/moesi_back.sv
module moesi_back import moesi_pkg::*; #(
    parameter int SETS = DEF_SETS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_nempty,
    input  t_op  i_op,
    output logic o_pop,
    output logic o_clearing,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_out
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    t_state r_state;
    logic [SET_W-1:0] r_clr_idx;
    t_op  r_op;
    logic r_valid;
    t_out r_out;

    logic [NWAYS*ST_W-1:0]  m_state [SETS];
    logic [NWAYS*TAG_W-1:0] m_tag   [SETS];
    logic [PLRU_W-1:0]      m_plru  [SETS];
    logic [NWAYS*ST_W-1:0]  r_st_row;
    logic [NWAYS*TAG_W-1:0] r_tag_row;
    logic [PLRU_W-1:0]      r_plru_row;

    logic [ST_W-1:0]        st [NWAYS];
    logic [NWAYS-1:0]       match;
    logic                   hit_any;
    logic [WAY_W-1:0]       hway;
    logic [WAY_W-1:0]       pway;
    logic [WAY_W-1:0]       way;
    logic [ST_W-1:0]        prev;
    logic [ST_W-1:0]        nst;
    t_out                   res;
    logic [NWAYS*ST_W-1:0]  n_st_row;
    logic [NWAYS*TAG_W-1:0] n_tag_row;
    logic [PLRU_W-1:0]      n_plru;
    logic                   tag_we;
    logic                   plru_we;
    logic                   upd;
    logic                   st_we;
    logic [SET_W-1:0]       w_set;
    logic [SET_W-1:0]       rd_set;
    logic                   rd_en;

    assign o_clearing = (r_state == S_CLEAR);
    assign o_pop      = (r_state == S_IDLE) && i_nempty;
    assign rd_en      = o_pop;
    assign rd_set     = i_op.set[SET_W-1:0];
    assign o_valid    = r_valid;
    assign o_out      = r_out;
    assign upd        = (r_state == S_LOOK) && (!r_valid || i_ready);

    // Tag match, victim choice and the resulting row updates.
    always_comb begin
        for (int w = 0; w < NWAYS; w++) begin
            st[w]    = r_st_row[w*ST_W +: ST_W];
            match[w] = (st[w] != ST_I) && (r_tag_row[w*TAG_W +: TAG_W] == r_op.tag);
        end
        hit_any = |match;
        hway = '0;
        for (int w = NWAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hway = WAY_W'(w);
            end
        end
        pway = plru_pick(r_plru_row);

        res       = '0;
        n_st_row  = r_st_row;
        n_tag_row = r_tag_row;
        n_plru    = r_plru_row;
        tag_we    = 1'b0;
        plru_we   = 1'b0;
        way       = hit_any ? hway : pway;
        prev      = st[way];
        nst       = prev;

        unique case (r_op.kind)
            K_RD, K_WR: begin
                plru_we = 1'b1;
                n_plru  = plru_touch(r_plru_row, way);
                res.way_used = way;
                if (hit_any) begin
                    res.hit = 1'b1;
                    if (r_op.kind == K_WR) begin
                        nst = ST_M;
                        res.bus_request = BUS_WR;
                    end
                end else begin
                    tag_we = 1'b1;
                    n_tag_row[way*TAG_W +: TAG_W] = r_op.tag;
                    res.victim_owned = (prev == ST_O) || (prev == ST_E) || (prev == ST_M);
                    if (r_op.kind == K_RD) begin
                        res.bus_request = BUS_RD;
                        nst = r_op.peer ? ST_S : ST_E;
                    end else begin
                        res.bus_request = BUS_RDX;
                        nst = ST_M;
                    end
                end
                res.new_state = nst;
            end
            K_SRD, K_SINV: begin
                if (hit_any) begin
                    res.hit = 1'b1;
                    res.way_used = way;
                    if (r_op.kind == K_SRD) begin
                        if (prev == ST_E || prev == ST_M) begin
                            nst = ST_O;
                        end
                        res.supply_data = (prev == ST_E) || (prev == ST_M) || (prev == ST_O);
                    end else begin
                        nst = ST_I;
                    end
                    res.new_state = nst;
                end
            end
            default: begin
                nst = prev;
            end
        endcase
        n_st_row[way*ST_W +: ST_W] = nst;
    end

    assign st_we = o_clearing || upd;
    assign w_set = o_clearing ? r_clr_idx : r_op.set[SET_W-1:0];

    // State memory, cleared row by row after reset.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            m_state[w_set] <= o_clearing ? '0 : n_st_row;
        end
        if (rd_en) begin
            r_st_row <= m_state[rd_set];
        end
    end

    // Tag memory, written on a fill only.
    always_ff @(posedge i_clk) begin
        if (upd && tag_we) begin
            m_tag[w_set] <= n_tag_row;
        end
        if (rd_en) begin
            r_tag_row <= m_tag[rd_set];
        end
    end

    // Pseudo-LRU memory, cleared with the state memory.
    always_ff @(posedge i_clk) begin
        if (o_clearing || (upd && plru_we)) begin
            m_plru[w_set] <= o_clearing ? '0 : n_plru;
        end
        if (rd_en) begin
            r_plru_row <= m_plru[rd_set];
        end
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (r_valid && i_ready && !upd) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == SET_W'(SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_nempty) begin
                        r_op    <= i_op;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (upd) begin
                        r_out   <= res;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/moesi_snooping_cache_controller.sv
// Tag and state controller of an 8-way set-associative MOESI snooping cache with a
// tree pseudo-LRU per set. Each transaction on the input channel is a CPU read or
// write or a snooped Rd, RdX or Wr; each gives exactly one result transaction. The
// front decodes the set and the command and feeds a two-entry queue; the back reads
// the tag, state and LRU rows of the set into registers and writes them back with
// the result in its look-up state, waiting while a result is held, then takes the
// next transaction. When SETS is not a power of two the front forms the set index
// four address bits at a time and takes no new transaction until it is passed on.
// After reset a clearing pass invalidates every line, during which no transaction
// is taken; the cache_id register may be written at any time the block is idle.
module moesi_snooping_cache_controller import moesi_pkg::*; #(
    parameter int SETS = DEF_SETS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in        i_in,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out       o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data
);

    logic [3:0] r_cache_id;
    logic       clearing;
    logic       full;
    logic       push;
    logic       nempty;
    logic       pop;
    t_op        f_op;
    t_op        q_op;

    assign o_cfg_ready = 1'b1;

    // Cache identifier register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_id <= '0;
        end else if (i_cfg_valid) begin
            r_cache_id <= i_cfg_data;
        end
    end

    moesi_front #(.SETS(SETS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .i_cache_id (r_cache_id),
        .i_clearing (clearing),
        .i_full     (full),
        .o_push     (push),
        .o_op       (f_op)
    );

    moesi_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (f_op),
        .o_full   (full),
        .o_nempty (nempty),
        .i_pop    (pop),
        .o_op     (q_op)
    );

    moesi_back #(.SETS(SETS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nempty   (nempty),
        .i_op       (q_op),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

endmodule

### tb/tb_top.sv
module tb_top;
    import moesi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Scoreboard: holds a behavioural copy of the tag, state and LRU arrays and
    // the queue of results still owed by the block.
    class cache_scoreboard;
        logic [2:0]  line_st [1024];
        logic [19:0] line_tg [1024];
        logic [6:0]  lru [128];
        logic [3:0]  own_id;
        t_out        owed [$];
        int          n_err;

        function void clear();
            foreach (line_st[i]) line_st[i] = ST_I;
            foreach (line_tg[i]) line_tg[i] = '0;
            foreach (lru[i]) lru[i] = '0;
            own_id = '0;
            owed.delete();
            n_err = 0;
        endfunction

        // Works out the result of one accepted transaction and updates the copy.
        function void note_input(t_in t);
            t_out r;
            logic [19:0] tg;
            logic [6:0] st;
            logic [6:0] tr;
            int base;
            int w;
            int k;
            r = '0;
            tg = t.address[31:12];
            st = t.address[11:5];
            base = st * 8;
            tr = lru[st];
            w = 8;
            for (k = 7; k >= 0; k--) begin
                if (line_st[base+k] != ST_I && line_tg[base+k] == tg) w = k;
            end
            if (t.cmd == CMD_CPU_RD || t.cmd == CMD_CPU_WR) begin
                if (w < 8) begin
                    r.hit = 1'b1;
                    if (t.cmd == CMD_CPU_WR) begin
                        line_st[base+w] = ST_M;
                        r.bus_request = BUS_WR;
                    end
                end else begin
                    // Tree walk: root, then pair, then way within the pair.
                    w = 4 * tr[0];
                    if (!tr[0]) w += tr[1] ? 2 : 0; else w += tr[2] ? 2 : 0;
                    w += tr[3 + w/2] ? 1 : 0;
                    r.victim_owned = (line_st[base+w] inside {ST_O, ST_E, ST_M});
                    if (t.cmd == CMD_CPU_RD) begin
                        r.bus_request = BUS_RD;
                        line_st[base+w] = t.peer_supplied ? ST_S : ST_E;
                    end else begin
                        r.bus_request = BUS_RDX;
                        line_st[base+w] = ST_M;
                    end
                    line_tg[base+w] = tg;
                end
                r.way_used = w[2:0];
                r.new_state = line_st[base+w];
                // Point the tree away from the way used.
                if (w < 4) begin
                    tr[0] = 1'b1;
                    tr[1] = (w < 2);
                end else begin
                    tr[0] = 1'b0;
                    tr[2] = (w < 6);
                end
                tr[3 + w/2] = ~w[0];
                lru[st] = tr;
            end else if (t.cmd inside {CMD_SN_RD, CMD_SN_RDX, CMD_SN_WR}
                         && t.requester_id != own_id && w < 8) begin
                r.hit = 1'b1;
                r.way_used = w[2:0];
                if (t.cmd == CMD_SN_RD) begin
                    r.supply_data = (line_st[base+w] inside {ST_O, ST_E, ST_M});
                    if (line_st[base+w] inside {ST_E, ST_M}) line_st[base+w] = ST_O;
                end else begin
                    line_st[base+w] = ST_I;
                end
                r.new_state = line_st[base+w];
            end
            owed.push_back(r);
        endfunction

        function void check_result(t_out a);
            t_out e;
            if (owed.size() == 0) begin
                $error("result with nothing expected: %h", a);
                n_err++;
                return;
            end
            e = owed.pop_front();
            if (a.hit !== e.hit) begin
                $error("hit: expected %0d, got %0d", e.hit, a.hit); n_err++;
            end
            if (a.bus_request !== e.bus_request) begin
                $error("bus_request: expected %0d, got %0d", e.bus_request, a.bus_request);
                n_err++;
            end
            if (a.way_used !== e.way_used) begin
                $error("way_used: expected %0d, got %0d", e.way_used, a.way_used); n_err++;
            end
            if (a.new_state !== e.new_state) begin
                $error("new_state: expected %0d, got %0d", e.new_state, a.new_state);
                n_err++;
            end
            if (a.victim_owned !== e.victim_owned) begin
                $error("victim_owned: expected %0d, got %0d", e.victim_owned, a.victim_owned);
                n_err++;
            end
            if (a.supply_data !== e.supply_data) begin
                $error("supply_data: expected %0d, got %0d", e.supply_data, a.supply_data);
                n_err++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in        i_in = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out       o_out;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data = '0;

    cache_scoreboard sb;
    bit   steady = 1'b0;
    int   n_sent = 0;
    int   n_seen = 0;
    int   cycles = 0;
    logic [19:0] tag_pool [6];

    moesi_snooping_cache_controller uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Result side: check each accepted result and stall at random.
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            sb.check_result(o_out);
            n_seen++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) i_ready <= steady ? 1'b1 : ($urandom_range(99) >= 6);
    end

    // Sends one transaction, with the odd idle cycle ahead of it. Valid stays
    // high into the next transaction unless an idle cycle or a drain drops it.
    task automatic send(t_in t);
        if (!steady) begin
            while ($urandom_range(99) < 6) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in <= t;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(t);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_id(logic [3:0] id);
        i_cfg_data <= id;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.own_id = id;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in make(logic [2:0] c, logic [19:0] tg, logic [6:0] st,
                                 logic [3:0] rq, logic pe);
        t_in t;
        t.cmd = c;
        t.address = {tg, st, 5'($urandom)};
        t.requester_id = rq;
        t.peer_supplied = pe;
        return t;
    endfunction

    // Mostly well-formed traffic on a few sets and tags so lines hit and evict.
    task automatic random_phase(int n);
        t_in t;
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 4) begin
                t = t_in'($urandom);
                t.address = $urandom;
                t.cmd = 3'($urandom);
            end else begin
                t = make(3'($urandom_range(4)), tag_pool[$urandom_range(5)],
                         7'($urandom_range(3)), 4'($urandom), 1'($urandom));
                if ($urandom_range(3) == 0) t.requester_id = sb.own_id;
            end
            send(t);
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        tag_pool = '{20'h00000, 20'hFFFFF, 20'h5A5A5, 20'hA5A5A, 20'h12345, 20'h00001};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: fills, hits, every snoop, own snoop, unused codes, extremes.
        send(make(CMD_CPU_RD, 20'hFFFFF, 7'h7F, 4'h0, 1'b0));
        send(make(CMD_CPU_RD, 20'hFFFFF, 7'h7F, 4'h0, 1'b1));
        send(make(CMD_CPU_WR, 20'hFFFFF, 7'h7F, 4'h0, 1'b0));
        send(make(CMD_SN_RD,  20'hFFFFF, 7'h7F, 4'hF, 1'b0));
        send(make(CMD_SN_RD,  20'hFFFFF, 7'h7F, 4'h0, 1'b0));
        send(make(CMD_SN_WR,  20'hFFFFF, 7'h7F, 4'h3, 1'b0));
        send(make(CMD_CPU_RD, 20'h00000, 7'h00, 4'h0, 1'b1));
        send(make(CMD_SN_RD,  20'h00000, 7'h00, 4'h1, 1'b0));
        send(make(CMD_SN_RDX, 20'h00000, 7'h00, 4'h2, 1'b0));
        for (int k = 0; k < 9; k++) send(make(CMD_CPU_WR, 20'(k + 7), 7'h01, 4'h0, 1'b0));
        send(make(3'd5, 20'h00007, 7'h01, 4'h9, 1'b1));
        send(make(3'd7, 20'hFFFFF, 7'h7F, 4'hF, 1'b1));
        send(make(CMD_SN_RDX, 20'h00000, 7'h00, 4'h4, 1'b0));
        wait_drained();

        set_id(4'hF);
        random_phase(150);
        // Hold off until every result is back, then carry on.
        wait_drained();
        random_phase(50);
        steady = 1'b1;
        random_phase(100);
        steady = 1'b0;
        wait_drained();
        set_id(4'h5);
        random_phase(130);
        wait_drained();
        set_id(4'h0);
        random_phase(120);
        wait_drained();

        $display("Sent %0d transactions over cache ids 0, 15, 5 and 0 again;", n_sent);
        $display("checked %0d results covering fills, hits, evictions and snoops.", n_seen);
        if (sb.n_err == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
sv/moesi_pkg.sv
sv/moesi_front.sv
sv/moesi_queue.sv
sv/moesi_back.sv
sv/moesi_snooping_cache_controller.sv
tb/tb_top.sv
